[hdl/dmfp_pkg.sv]
// ----------------------------------------------------------------------------
// dmfp_pkg
// Shared constants for the DNS message field parser: parse phase codes,
// field kind codes, status codes and stream packing widths.
// ----------------------------------------------------------------------------
`default_nettype none

package dmfp_pkg;

  // Parse phase codes
  localparam int PhaseW = 4;
  localparam logic [PhaseW-1:0] PH_HDR    = 4'd0;
  localparam logic [PhaseW-1:0] PH_QNAME  = 4'd1;
  localparam logic [PhaseW-1:0] PH_QLABEL = 4'd2;
  localparam logic [PhaseW-1:0] PH_QTYPE  = 4'd3;
  localparam logic [PhaseW-1:0] PH_QCLASS = 4'd4;
  localparam logic [PhaseW-1:0] PH_ANAME  = 4'd5;
  localparam logic [PhaseW-1:0] PH_ATYPE  = 4'd6;
  localparam logic [PhaseW-1:0] PH_ACLASS = 4'd7;
  localparam logic [PhaseW-1:0] PH_ATTL   = 4'd8;
  localparam logic [PhaseW-1:0] PH_ARDLEN = 4'd9;
  localparam logic [PhaseW-1:0] PH_RDATA  = 4'd10;
  localparam logic [PhaseW-1:0] PH_IGNORE = 4'd11;

  // Field kind codes
  localparam int KindW = 5;
  localparam logic [KindW-1:0] KIND_NONE    = 5'd0;
  localparam logic [KindW-1:0] KIND_ID      = 5'd1;
  localparam logic [KindW-1:0] KIND_QLABEL  = 5'd7;
  localparam logic [KindW-1:0] KIND_QLEN    = 5'd8;
  localparam logic [KindW-1:0] KIND_QTYPE   = 5'd9;
  localparam logic [KindW-1:0] KIND_QCLASS  = 5'd10;
  localparam logic [KindW-1:0] KIND_TYPE    = 5'd11;
  localparam logic [KindW-1:0] KIND_CLASS   = 5'd12;
  localparam logic [KindW-1:0] KIND_TTL     = 5'd13;
  localparam logic [KindW-1:0] KIND_RDLEN   = 5'd14;
  localparam logic [KindW-1:0] KIND_RDATA   = 5'd15;
  localparam logic [KindW-1:0] KIND_ANAME   = 5'd16;

  // Status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_TOO_SHORT   = 2'd1;
  localparam logic [1:0] ST_MANY_QUEST  = 2'd2;
  localparam logic [1:0] ST_MANY_ANSWER = 2'd3;

  // Message layout
  localparam logic [3:0]  HEADER_BYTES = 4'd12;
  localparam logic [15:0] LIMIT_RESET  = 16'd256;
  localparam logic [15:0] TYPE_A       = 16'd1;
  localparam logic [15:0] TYPE_AAAA    = 16'd28;

  // Stream packing
  localparam int ValueW  = 32;
  localparam int RecordW = 16;
  localparam int OutDataW = 56;   // 32 + 16 + 2 = 50, padded to bytes
  localparam int OutUserW = 6;    // kind + address flag
  localparam int ValLo  = 0;
  localparam int RecLo  = 32;
  localparam int StatLo = 48;

endpackage

`default_nettype wire

[hdl/dns_message_field_parser.sv]
// A result appears on the master side in the cycle after its byte's transfer.
// Throughput: one message byte per cycle unless a held result is stalled by
// m_tready; the output register is refilled in the same cycle it is drained.
// Reset (rst, synchronous): parse state returns to the first header byte,
// the output register empties, count_limit returns to 256.
// ----------------------------------------------------------------------------
// dns_message_field_parser
// Byte-serial DNS message parser: emits header words, question name bytes,
// qtype/qclass and answer fixed fields plus rdata bytes as tagged fields.
// ----------------------------------------------------------------------------
`default_nettype none

module dns_message_field_parser
  import dmfp_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  // configuration
  input  wire logic                cfg_wen,
  input  wire logic [15:0]         cfg_wdata,   // count_limit
  // byte stream in
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [7:0]          s_tdata,     // [7:0] data_byte
  input  wire logic                s_tlast,     // last_byte
  // field stream out
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [OutDataW-1:0]      m_tdata,     // [31:0] field_value, [47:32] record_index,
                                                // [49:48] status, [55:50] zero
  output logic [OutUserW-1:0]      m_tuser,     // [4:0] field_kind, [5] address_data
  output logic                     m_tlast      // message_end
);

  // parse state
  logic [PhaseW-1:0]  phase, phase_next;
  logic [3:0]         bif, bif_next;
  logic [31:0]        acc, acc_next;
  logic [15:0]        qcount, qcount_next;
  logic [15:0]        acount, acount_next;
  logic [15:0]        rec, rec_next;
  logic [15:0]        left, left_next;
  logic               is_addr, is_addr_next;
  logic [1:0]         stop, stop_next;
  logic [15:0]        count_limit;

  // output register
  logic               out_valid;
  logic [KindW-1:0]   out_kind;
  logic [ValueW-1:0]  out_value;
  logic [RecordW-1:0] out_rec;
  logic               out_addr;
  logic               out_last;
  logic [1:0]         out_status;

  // per-byte results
  logic [KindW-1:0]   kind;
  logic [ValueW-1:0]  value;
  logic [RecordW-1:0] rec_out;
  logic               addr;
  logic [1:0]         status;
  logic               emit;
  logic               accept;

  // working values
  logic [31:0]        acc_sh;
  logic [3:0]         bif_inc;
  logic [2:0]         word;
  logic [15:0]        rec_inc;
  logic [15:0]        left_dec;
  logic [3:0]         flen;

  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    phase_next   = phase;
    bif_next     = bif;
    acc_next     = acc;
    qcount_next  = qcount;
    acount_next  = acount;
    rec_next     = rec;
    left_next    = left;
    is_addr_next = is_addr;
    stop_next    = stop;

    kind    = KIND_NONE;
    value   = '0;
    rec_out = rec;
    addr    = 1'b0;

    acc_sh   = {acc[23:0], s_tdata};
    bif_inc  = bif + 4'd1;
    word     = bif_inc[3:1] - 3'd1;
    rec_inc  = rec + 16'd1;
    left_dec = left - 16'd1;
    flen     = (phase == PH_ATTL) ? 4'd4 : 4'd2;

    unique case (phase)
      PH_HDR: begin
        acc_next = acc_sh;
        bif_next = bif_inc;
        rec_out  = '0;
        if (!bif_inc[0]) begin
          kind  = KIND_ID + {2'b00, word};
          value = {16'h0000, acc_sh[15:0]};
          if (word == 3'd2) qcount_next = acc_sh[15:0];
          if (word == 3'd3) acount_next = acc_sh[15:0];
        end
        if (bif_inc >= HEADER_BYTES) begin
          bif_next = '0;
          acc_next = '0;
          rec_next = '0;
          if (qcount_next >= count_limit) begin
            stop_next  = ST_MANY_QUEST;
            phase_next = PH_IGNORE;
          end else if (qcount_next == 16'd0) begin
            if (acount_next >= count_limit) begin
              stop_next  = ST_MANY_ANSWER;
              phase_next = PH_IGNORE;
            end else if (acount_next == 16'd0) begin
              phase_next = PH_IGNORE;
            end else begin
              phase_next = PH_ANAME;
            end
          end else begin
            phase_next = PH_QNAME;
          end
        end
      end
      PH_QNAME: begin
        kind  = KIND_QLEN;
        value = {24'h000000, s_tdata};
        if (s_tdata == 8'h00) begin
          bif_next   = '0;
          acc_next   = '0;
          phase_next = PH_QTYPE;
        end else begin
          left_next  = {8'h00, s_tdata};
          phase_next = PH_QLABEL;
        end
      end
      PH_QLABEL: begin
        kind      = KIND_QLABEL;
        value     = {24'h000000, s_tdata};
        left_next = left_dec;
        if (left_dec == 16'd0) phase_next = PH_QNAME;
      end
      PH_QTYPE, PH_QCLASS, PH_ANAME, PH_ATYPE, PH_ACLASS, PH_ATTL, PH_ARDLEN: begin
        acc_next = acc_sh;
        bif_next = bif_inc;
        if (bif_inc >= flen) begin
          value    = (phase == PH_ATTL) ? acc_sh : {16'h0000, acc_sh[15:0]};
          bif_next = '0;
          acc_next = '0;
          unique case (phase)
            PH_QTYPE: begin
              kind       = KIND_QTYPE;
              phase_next = PH_QCLASS;
            end
            PH_QCLASS: begin
              kind     = KIND_QCLASS;
              rec_next = rec_inc;
              if (rec_inc < qcount) begin
                phase_next = PH_QNAME;
              end else begin
                rec_next = '0;
                if (acount >= count_limit) begin
                  stop_next  = ST_MANY_ANSWER;
                  phase_next = PH_IGNORE;
                end else if (acount == 16'd0) begin
                  phase_next = PH_IGNORE;
                end else begin
                  phase_next = PH_ANAME;
                end
              end
            end
            PH_ANAME: begin
              kind       = KIND_ANAME;
              phase_next = PH_ATYPE;
            end
            PH_ATYPE: begin
              kind         = KIND_TYPE;
              is_addr_next = (acc_sh[15:0] == TYPE_A) || (acc_sh[15:0] == TYPE_AAAA);
              phase_next   = PH_ACLASS;
            end
            PH_ACLASS: begin
              kind       = KIND_CLASS;
              phase_next = PH_ATTL;
            end
            PH_ATTL: begin
              kind       = KIND_TTL;
              phase_next = PH_ARDLEN;
            end
            default: begin
              kind      = KIND_RDLEN;
              left_next = acc_sh[15:0];
              if (acc_sh[15:0] != 16'd0) begin
                phase_next = PH_RDATA;
              end else begin
                rec_next   = rec_inc;
                phase_next = (rec_inc < acount) ? PH_ANAME : PH_IGNORE;
              end
            end
          endcase
        end
      end
      PH_RDATA: begin
        kind      = KIND_RDATA;
        value     = {24'h000000, s_tdata};
        addr      = is_addr;
        left_next = left_dec;
        if (left_dec == 16'd0) begin
          rec_next   = rec_inc;
          phase_next = (rec_inc < acount) ? PH_ANAME : PH_IGNORE;
        end
      end
      default: begin
        // ignore phase: bytes are dropped until the final one
      end
    endcase

    if (kind == KIND_NONE) rec_out = '0;

    if (s_tlast) begin
      status = (phase_next == PH_IGNORE) ? stop_next : ST_TOO_SHORT;
    end else begin
      status = ST_OK;
    end
    emit = (kind != KIND_NONE) || s_tlast;

    // final byte: start the next message from a clean state
    if (s_tlast) begin
      phase_next   = PH_HDR;
      bif_next     = '0;
      acc_next     = '0;
      qcount_next  = '0;
      acount_next  = '0;
      rec_next     = '0;
      left_next    = '0;
      is_addr_next = 1'b0;
      stop_next    = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HDR;
      bif         <= '0;
      acc         <= '0;
      qcount      <= '0;
      acount      <= '0;
      rec         <= '0;
      left        <= '0;
      is_addr     <= 1'b0;
      stop        <= ST_OK;
      count_limit <= LIMIT_RESET;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wen) count_limit <= cfg_wdata;
      if (accept) begin
        phase     <= phase_next;
        bif       <= bif_next;
        acc       <= acc_next;
        qcount    <= qcount_next;
        acount    <= acount_next;
        rec       <= rec_next;
        left      <= left_next;
        is_addr   <= is_addr_next;
        stop      <= stop_next;
        out_valid <= emit;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload register, loaded on any transfer that produces a field or ends a message
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_kind   <= kind;
      out_value  <= value;
      out_rec    <= rec_out;
      out_addr   <= addr;
      out_last   <= s_tlast;
      out_status <= status;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'b000000, out_status, out_rec, out_value};
  assign m_tuser  = {out_addr, out_kind};
  assign m_tlast  = out_last;

endmodule

`default_nettype wire

[hdl/dmfp_checker.sv]
// ----------------------------------------------------------------------------
// dmfp_checker
// Port-level checks for the DNS message field parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dmfp_checker
  import dmfp_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                s_tready,
  input wire logic                m_tvalid,
  input wire logic                m_tready,
  input wire logic [OutDataW-1:0] m_tdata,
  input wire logic [OutUserW-1:0] m_tuser,
  input wire logic                m_tlast
);

  // a held result keeps its contents until the transfer
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("output changed while stalled");

  // an empty output register never blocks the input side
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // status only on the end-of-message result
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[StatLo+1:StatLo] == ST_OK)
    else $error("status outside message end");

  // a field-less result is only the end marker, with zero value and record
  a_none: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[KindW-1:0] == KIND_NONE |->
      m_tlast && m_tdata[StatLo-1:0] == '0 && !m_tuser[KindW])
    else $error("empty field not at message end");

  // address flag appears on rdata bytes only
  a_addr: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[KindW] |-> m_tuser[KindW-1:0] == KIND_RDATA)
    else $error("address flag on non-rdata field");

endmodule

bind dns_message_field_parser dmfp_checker u_dmfp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire

[tb/tb_dns_message_field_parser.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dns_message_field_parser
// Streams generated DNS messages byte by byte into the parser, predicts every
// emitted field as each byte transfer happens, and checks the field stream
// field by field. Covers several count_limit settings, truncated messages,
// too-many counts, random idle on both sides and a long output stall.
// ----------------------------------------------------------------------------
module tb_dns_message_field_parser;
  import dmfp_pkg::*;

  localparam int WordBytes  = 2;
  localparam int TtlBytes   = 4;
  localparam int IdlePct    = 26;
  localparam int StallLimit = 2000;
  localparam int HoldCycles = 80;
  localparam int MaxReports = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } msg_byte_t;

  typedef struct {
    logic [KindW-1:0]   kind;
    logic [ValueW-1:0]  value;
    logic [RecordW-1:0] record;
    logic               addr;
    logic               last;
    logic [1:0]         status;
  } field_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_wen = 1'b0;
  logic [15:0]         cfg_wdata = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [7:0]          s_tdata = '0;
  logic                s_tlast = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic [OutUserW-1:0] m_tuser;
  logic                m_tlast;

  dns_message_field_parser uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  msg_byte_t bytes_to_send[$];
  field_t    fields_due[$];
  msg_byte_t next_byte;
  field_t    want;
  bit        byte_taken = 1'b0;
  bit        gaps_on = 1'b1;
  int        hold_left = 0;
  int        errors = 0;
  int        quiet_cycles = 0;
  int        sent_total = 0;

  // parser state as the block should hold it
  logic [PhaseW-1:0]  phase;
  logic [3:0]         fld_cnt;
  logic [31:0]        acc;
  logic [15:0]        n_quest;
  logic [15:0]        n_ans;
  logic [15:0]        rec_idx;
  logic [15:0]        run_left;
  logic               is_addr;
  logic [1:0]         stop_code;
  logic [15:0]        limit;

  function automatic void clear_parse();
    phase     = PH_HDR;
    fld_cnt   = '0;
    acc       = '0;
    n_quest   = '0;
    n_ans     = '0;
    rec_idx   = '0;
    run_left  = '0;
    is_addr   = 1'b0;
    stop_code = ST_OK;
  endfunction

  function automatic void start_answers();
    rec_idx = '0;
    if (n_ans >= limit) begin
      stop_code = ST_MANY_ANSWER;
      phase = PH_IGNORE;
    end else if (n_ans == 0) begin
      phase = PH_IGNORE;
    end else begin
      phase = PH_ANAME;
    end
  endfunction

  function automatic void next_answer();
    rec_idx = rec_idx + 16'd1;
    phase = (rec_idx < n_ans) ? PH_ANAME : PH_IGNORE;
  endfunction

  // Advance the parser by one byte; queue the field it completes, if any.
  function automatic void parse_dns_byte(input logic [7:0] b, input logic last);
    field_t f;
    logic [PhaseW-1:0] done;
    f.kind   = KIND_NONE;
    f.value  = '0;
    f.record = rec_idx;
    f.addr   = 1'b0;
    f.last   = last;
    f.status = ST_OK;
    case (phase)
      PH_HDR: begin
        acc = {acc[23:0], b};
        fld_cnt = fld_cnt + 4'd1;
        f.record = '0;
        if (!fld_cnt[0]) begin
          f.kind  = KIND_ID + {2'b00, fld_cnt[3:1]} - 5'd1;
          f.value = {16'd0, acc[15:0]};
          // third and fourth header words are qdcount and ancount
          if (fld_cnt == 4'd6) n_quest = acc[15:0];
          if (fld_cnt == 4'd8) n_ans = acc[15:0];
        end
        if (fld_cnt >= HEADER_BYTES) begin
          fld_cnt = '0;
          acc     = '0;
          rec_idx = '0;
          if (n_quest >= limit) begin
            stop_code = ST_MANY_QUEST;
            phase = PH_IGNORE;
          end else if (n_quest == 0) begin
            start_answers();
          end else begin
            phase = PH_QNAME;
          end
        end
      end
      PH_QNAME: begin
        f.kind  = KIND_QLEN;
        f.value = {24'd0, b};
        if (b == 8'd0) begin
          fld_cnt = '0;
          acc     = '0;
          phase   = PH_QTYPE;
        end else begin
          run_left = {8'd0, b};
          phase    = PH_QLABEL;
        end
      end
      PH_QLABEL: begin
        f.kind  = KIND_QLABEL;
        f.value = {24'd0, b};
        run_left = run_left - 16'd1;
        if (run_left == 0) phase = PH_QNAME;
      end
      PH_QTYPE, PH_QCLASS, PH_ANAME, PH_ATYPE, PH_ACLASS, PH_ATTL, PH_ARDLEN: begin
        acc = {acc[23:0], b};
        fld_cnt = fld_cnt + 4'd1;
        if (fld_cnt >= ((phase == PH_ATTL) ? TtlBytes : WordBytes)) begin
          done    = phase;
          f.value = (done == PH_ATTL) ? acc : {16'd0, acc[15:0]};
          fld_cnt = '0;
          acc     = '0;
          case (done)
            PH_QTYPE: begin
              f.kind = KIND_QTYPE;
              phase = PH_QCLASS;
            end
            PH_QCLASS: begin
              f.kind = KIND_QCLASS;
              rec_idx = rec_idx + 16'd1;
              if (rec_idx < n_quest) phase = PH_QNAME;
              else start_answers();
            end
            PH_ANAME: begin
              f.kind = KIND_ANAME;
              phase = PH_ATYPE;
            end
            PH_ATYPE: begin
              f.kind = KIND_TYPE;
              is_addr = (f.value[15:0] == TYPE_A) || (f.value[15:0] == TYPE_AAAA);
              phase = PH_ACLASS;
            end
            PH_ACLASS: begin
              f.kind = KIND_CLASS;
              phase = PH_ATTL;
            end
            PH_ATTL: begin
              f.kind = KIND_TTL;
              phase = PH_ARDLEN;
            end
            default: begin
              f.kind = KIND_RDLEN;
              run_left = f.value[15:0];
              if (run_left != 0) phase = PH_RDATA;
              else next_answer();
            end
          endcase
        end
      end
      PH_RDATA: begin
        f.kind  = KIND_RDATA;
        f.value = {24'd0, b};
        f.addr  = is_addr;
        run_left = run_left - 16'd1;
        if (run_left == 0) next_answer();
      end
      default: ;
    endcase
    if (f.kind == KIND_NONE) f.record = '0;
    if (last) f.status = (phase == PH_IGNORE) ? stop_code : ST_TOO_SHORT;
    if (f.kind != KIND_NONE || last) fields_due.push_back(f);
    if (last) clear_parse();
  endfunction

  // Build one message: header counts qd/an, nq questions and na answers actually
  // present, tail junk bytes, then optionally cut down to cut bytes.
  task automatic queue_message(input logic [15:0] qd, input logic [15:0] an,
                               input int nq, input int na, input int cut, input int tail);
    logic [7:0]  m[$];
    logic [15:0] rtype;
    int          rdlen;
    int          nlab;
    int          llen;
    int          r;
    repeat (4) m.push_back(8'($urandom_range(255)));
    m.push_back(qd[15:8]);
    m.push_back(qd[7:0]);
    m.push_back(an[15:8]);
    m.push_back(an[7:0]);
    repeat (4) m.push_back(8'($urandom_range(255)));
    for (int q = 0; q < nq; q++) begin
      nlab = $urandom_range(0, 3);
      for (int l = 0; l < nlab; l++) begin
        r = $urandom_range(31);
        llen = (r == 0) ? $urandom_range(64, 255) :
               (r < 4)  ? $urandom_range(7, 63) : $urandom_range(1, 6);
        m.push_back(8'(llen));
        repeat (llen) m.push_back(8'($urandom_range(255)));
      end
      m.push_back(8'd0);
      repeat (4) m.push_back(8'($urandom_range(255)));
    end
    for (int a = 0; a < na; a++) begin
      m.push_back(($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'hC0);
      m.push_back(8'($urandom_range(255)));
      r = $urandom_range(3);
      rtype = (r == 0) ? TYPE_A : (r == 1) ? TYPE_AAAA : 16'($urandom);
      m.push_back(rtype[15:8]);
      m.push_back(rtype[7:0]);
      repeat (6) m.push_back(8'($urandom_range(255)));
      if ($urandom_range(5) == 0) rdlen = $urandom_range(0, 8);
      else if (rtype == TYPE_A) rdlen = 4;
      else if (rtype == TYPE_AAAA) rdlen = 16;
      else rdlen = $urandom_range(0, 5);
      m.push_back(8'(rdlen >> 8));
      m.push_back(8'(rdlen));
      repeat (rdlen) m.push_back(8'($urandom_range(255)));
    end
    repeat (tail) m.push_back(8'($urandom_range(255)));
    while (cut > 0 && m.size() > cut) void'(m.pop_back());
    foreach (m[i]) bytes_to_send.push_back('{data: m[i], last: (i == m.size() - 1)});
    sent_total += m.size();
  endtask

  task automatic write_limit(input logic [15:0] v);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    limit = v;
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic wait_drained();
    while (bytes_to_send.size() != 0 || s_tvalid || fields_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // byte transfers feed the predictor
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      parse_dns_byte(s_tdata, s_tlast);
      byte_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (!rst && (!s_tvalid || byte_taken)) begin
      byte_taken = 1'b0;
      if (bytes_to_send.size() != 0 && !(gaps_on && $urandom_range(99) < IdlePct)) begin
        next_byte = bytes_to_send.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= next_byte.data;
        s_tlast  <= next_byte.last;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= !(gaps_on && $urandom_range(99) < IdlePct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (fields_due.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("unexpected field: kind %0d value %h rec %0d end %b status %0d",
                   m_tuser[KindW-1:0], m_tdata[ValLo +: ValueW],
                   m_tdata[RecLo +: RecordW], m_tlast, m_tdata[StatLo +: 2]);
      end else begin
        want = fields_due.pop_front();
        if (m_tuser[KindW-1:0] !== want.kind || m_tdata[ValLo +: ValueW] !== want.value ||
            m_tdata[RecLo +: RecordW] !== want.record || m_tuser[KindW] !== want.addr ||
            m_tlast !== want.last || m_tdata[StatLo +: 2] !== want.status) begin
          errors++;
          if (errors <= MaxReports)
            $display({"field mismatch: expected kind %0d value %h rec %0d addr %b end %b",
                      " st %0d, got kind %0d value %h rec %0d addr %b end %b st %0d"},
                     want.kind, want.value, want.record, want.addr, want.last, want.status,
                     m_tuser[KindW-1:0], m_tdata[ValLo +: ValueW], m_tdata[RecLo +: RecordW],
                     m_tuser[KindW], m_tlast, m_tdata[StatLo +: 2]);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("tb_dns_message_field_parser: FAIL");
      $finish;
    end
  end

  initial begin
    int nq;
    int na;
    int cut;
    int target;
    logic [15:0] qd;
    logic [15:0] an;
    clear_parse();
    limit = LIMIT_RESET;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed, limit at its reset value
    queue_message(16'd0, 16'd0, 0, 0, 1, 0);      // one-byte message
    queue_message(16'd0, 16'd0, 0, 0, 0, 1);      // header only, junk after
    queue_message(16'd1, 16'd2, 1, 2, 0, 0);
    queue_message(LIMIT_RESET, 16'd0, 0, 0, 0, 2);
    queue_message(16'd0, LIMIT_RESET, 0, 0, 0, 1);
    queue_message(16'd2, 16'd1, 2, 1, 20, 0);     // ends mid-question
    wait_drained();

    write_limit(16'd1);
    queue_message(16'd0, 16'd0, 0, 0, 0, 0);
    queue_message(16'd1, 16'd0, 0, 0, 0, 1);
    queue_message(16'd0, 16'd1, 0, 0, 0, 0);
    wait_drained();

    // zero limit stops every message right after the header
    write_limit(16'd0);
    queue_message(16'd0, 16'd0, 0, 0, 0, 1);
    wait_drained();

    write_limit(16'hFFFF);
    queue_message(16'hFFFF, 16'd0, 0, 0, 0, 0);
    queue_message(16'd0, 16'hFFFF, 0, 0, 0, 1);
    queue_message(16'hFFFE, 16'd0, 1, 0, 0, 0);
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: write_limit(16'd2);
        1: write_limit(16'd3);
        default: write_limit(($urandom_range(3) == 0) ? 16'($urandom_range(1, 4)) :
                             16'($urandom_range(1, 65535)));
      endcase
      gaps_on = (p != 3);
      target = sent_total + 40;
      while (sent_total < target) begin
        nq = $urandom_range(0, 3);
        na = $urandom_range(0, 3);
        qd = ($urandom_range(7) == 0) ? 16'($urandom) : 16'(nq);
        an = ($urandom_range(7) == 0) ? 16'($urandom) : 16'(na);
        cut = ($urandom_range(4) == 0) ? $urandom_range(1, 60) : 0;
        queue_message(qd, an, nq, na, cut, $urandom_range(0, 2));
      end
      // output held off while the sender keeps offering bytes
      if (p == 5) hold_left = HoldCycles;
      wait_drained();
    end

    if (errors == 0 && fields_due.size() == 0) begin
      $display("tb_dns_message_field_parser: PASS");
    end else begin
      $display("tb_dns_message_field_parser: FAIL");
    end
    $finish;
  end

endmodule
